@@ rtl/b64d_pkg.sv @@
// Shared types, character codes and the sextet lookup for the base64 stream decoder.
`default_nettype none
package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;

    localparam logic [7:0] OFFSET_LC  = 8'd26;
    localparam logic [7:0] OFFSET_DIG = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Command word handed from the front end to the output side.
    typedef struct packed {
        logic        err;
        logic        emit2;
        logic        emit3;
        logic [23:0] data;
    } t_cmd;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet    res;
        logic [7:0] tmp;
        res.bad   = 1'b0;
        res.value = '0;
        tmp       = '0;
        case (ch) inside
            [CHAR_UC_A:CHAR_UC_Z]: begin
                tmp       = ch - CHAR_UC_A;
                res.value = tmp[5:0];
            end
            [CHAR_LC_A:CHAR_LC_Z]: begin
                tmp       = ch - CHAR_LC_A + OFFSET_LC;
                res.value = tmp[5:0];
            end
            [CHAR_DIG_0:CHAR_DIG_9]: begin
                tmp       = ch - CHAR_DIG_0 + OFFSET_DIG;
                res.value = tmp[5:0];
            end
            CHAR_PLUS:  res.value = SEXTET_PLUS;
            CHAR_SLASH: res.value = SEXTET_SLASH;
            CHAR_PAD:   res.value = '0;
            default:    res.bad   = 1'b1;
        endcase
        return res;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CHAR_LF) || (ch == CHAR_CR) || (ch == CHAR_SPACE) || (ch == CHAR_TAB);
    endfunction

endpackage
`default_nettype wire

@@ rtl/base64_stream_decoder_unit.sv @@
// Each command is registered into the queue; its words reach the result ports at its head.
// Throughput: one character per cycle; a group of four characters gives up to three results,
// drained one per cycle while i_pop is high, from a four-entry command queue between front
// end and output side. Input stalls only when that queue is full.
// Reset (synchronous, active low) clears the sextet collector, the halt flag and the queue.
`default_nettype none
module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_stream,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_invalid,
    output logic            o_run_end
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic front_vld;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    b64d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_char       (i_in_char),
        .i_end_of_stream (i_end_of_stream),
        .o_cmd           (front_cmd),
        .o_cmd_vld       (front_vld)
    );

    b64d_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_vld),
        .i_wr_data (front_cmd),
        .i_rd_en   (q_pop),
        .o_rd_data (head_cmd),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_invalid   (o_invalid),
        .o_run_end   (o_run_end)
    );

endmodule
`default_nettype wire

@@ rtl/b64d_front.sv @@
// Front end: classifies characters, collects sextets and issues group or error commands.
`default_nettype none
module b64d_front
    import b64d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_stream,
    output t_cmd            o_cmd,
    output logic            o_cmd_vld
);

    logic [5:0] r_store0, r_store1, r_store2;
    logic [5:0] n_store0, n_store1, n_store2;
    logic       r_pad3, n_pad3;
    logic [1:0] r_count, n_count;
    logic       r_halted, n_halted;
    t_sextet    sx;

    always_comb begin
        sx        = sextet_of(i_in_char);
        n_store0  = r_store0;
        n_store1  = r_store1;
        n_store2  = r_store2;
        n_pad3    = r_pad3;
        n_count   = r_count;
        n_halted  = r_halted;
        o_cmd     = '0;
        o_cmd_vld = 1'b0;
        if (i_accept) begin
            if (!r_halted && !is_space(i_in_char)) begin
                if (sx.bad) begin
                    o_cmd_vld = 1'b1;
                    o_cmd.err = 1'b1;
                    n_halted  = 1'b1;
                end else begin
                    case (r_count)
                        2'd0: begin
                            n_store0 = sx.value;
                            n_count  = 2'd1;
                        end
                        2'd1: begin
                            n_store1 = sx.value;
                            n_count  = 2'd2;
                        end
                        2'd2: begin
                            n_store2 = sx.value;
                            n_pad3   = (i_in_char == CHAR_PAD);
                            n_count  = 2'd3;
                        end
                        default: begin
                            o_cmd_vld   = 1'b1;
                            o_cmd.data  = {r_store0, r_store1, r_store2, sx.value};
                            o_cmd.emit2 = !r_pad3;
                            o_cmd.emit3 = (i_in_char != CHAR_PAD);
                            n_store0    = '0;
                            n_store1    = '0;
                            n_store2    = '0;
                            n_pad3      = 1'b0;
                            n_count     = 2'd0;
                        end
                    endcase
                end
            end
            if (i_end_of_stream) begin
                n_store0 = '0;
                n_store1 = '0;
                n_store2 = '0;
                n_pad3   = 1'b0;
                n_count  = 2'd0;
                n_halted = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store0 <= '0;
            r_store1 <= '0;
            r_store2 <= '0;
            r_pad3   <= 1'b0;
            r_count  <= 2'd0;
            r_halted <= 1'b0;
        end else begin
            r_store0 <= n_store0;
            r_store1 <= n_store1;
            r_store2 <= n_store2;
            r_pad3   <= n_pad3;
            r_count  <= n_count;
            r_halted <= n_halted;
        end
    end

endmodule
`default_nettype wire

@@ rtl/b64d_fifo.sv @@
// Short command queue between the front end and the output side.
`default_nettype none
module b64d_fifo
    import b64d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_en,
    input  wire t_cmd i_wr_data,
    input  wire logic i_rd_en,
    output t_cmd      o_rd_data,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                do_wr, do_rd;

    assign o_full    = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ rtl/b64d_back.sv @@
// Output side: expands one queued command into its sequence of result words.
`default_nettype none
module b64d_back
    import b64d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cmd_empty,
    output logic            o_cmd_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_invalid,
    output logic            o_run_end
);

    logic [1:0] r_idx, n_idx;
    logic [1:0] last_idx;
    logic       take;

    assign o_empty = i_cmd_empty;
    assign take    = i_pop && !i_cmd_empty;

    always_comb begin
        if (i_cmd.err) begin
            last_idx = 2'd0;
        end else begin
            last_idx = 2'(i_cmd.emit2) + 2'(i_cmd.emit3);
        end
        case (r_idx)
            2'd0:    o_out_byte = i_cmd.data[23:16];
            2'd1:    o_out_byte = i_cmd.emit2 ? i_cmd.data[15:8] : i_cmd.data[7:0];
            default: o_out_byte = i_cmd.data[7:0];
        endcase
        if (i_cmd.err) begin
            o_out_byte = '0;
        end
        o_invalid = i_cmd.err;
        o_run_end = (r_idx == last_idx);
        o_cmd_pop = take && o_run_end;
        n_idx     = r_idx;
        if (take) begin
            n_idx = o_run_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule
`default_nettype wire

@@ test/base64_stream_decoder_unit_test.sv @@
// Self-checking testbench for the base64 stream decoder: directed table, then random streams.
`default_nettype none
module base64_stream_decoder_unit_test;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       last;
    } t_decoded;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eos;
        logic        typed;
        logic [1:0]  n;
        logic [23:0] bytes;
        logic        bad;
    } t_dir_row;

    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{"T",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"W",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"F",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"u",        1'b0, 1'b1, 2'd3, 24'h4D616E, 1'b0},
        '{"/",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"/",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{CHAR_LF,    1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"+",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"/",        1'b0, 1'b1, 2'd3, 24'hFFFFBF, 1'b0},
        '{"Q",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"Q",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{CHAR_PAD,   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{CHAR_PAD,   1'b0, 1'b1, 2'd1, 24'h410000, 1'b0},
        '{"A",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"B",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{CHAR_PAD,   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"C",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"z",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"9",        1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"a",        1'b1, 1'b1, 2'd0, 24'h000000, 1'b0},
        '{CHAR_TAB,   1'b1, 1'b1, 2'd0, 24'h000000, 1'b0},
        '{8'h00,      1'b0, 1'b1, 2'd1, 24'h000000, 1'b1},
        '{"A",        1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
        '{"B",        1'b1, 1'b1, 2'd0, 24'h000000, 1'b0},
        '{8'hFF,      1'b1, 1'b1, 2'd1, 24'h000000, 1'b1}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [7:0] i_in_char = 8'h00;
    logic       i_end_of_stream = 1'b0;
    logic       i_pop = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_out_byte;
    logic       o_invalid;
    logic       o_run_end;

    t_decoded   expected_bytes [$];
    t_decoded   popped;

    logic [5:0] held_sextets [0:2];
    logic       third_pad = 1'b0;
    logic [1:0] filled = 2'd0;
    logic       halted = 1'b0;

    int         symbols_seen = 0;
    int         failures = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    int         hold_left = 0;
    int         pop_cycle = 0;
    int         pop_mode = 0;
    bit         hold_req = 1'b0;
    bit         finishing = 1'b0;

    base64_stream_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_in_char       (i_in_char),
        .i_end_of_stream (i_end_of_stream),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_out_byte      (o_out_byte),
        .o_invalid       (o_invalid),
        .o_run_end       (o_run_end)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == CHAR_LF || ch == CHAR_CR || ch == CHAR_SPACE || ch == CHAR_TAB;
    endfunction

    // Bit 6 flags a character outside the alphabet.
    function automatic logic [6:0] char_value(input logic [7:0] ch);
        if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) return {1'b0, 6'(ch - CHAR_UC_A)};
        if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) return {1'b0, 6'(ch - CHAR_LC_A + OFFSET_LC)};
        if (ch >= CHAR_DIG_0 && ch <= CHAR_DIG_9) return {1'b0, 6'(ch - CHAR_DIG_0 + OFFSET_DIG)};
        if (ch == CHAR_PLUS) return {1'b0, SEXTET_PLUS};
        if (ch == CHAR_SLASH) return {1'b0, SEXTET_SLASH};
        if (ch == CHAR_PAD) return 7'h00;
        return 7'h40;
    endfunction

    function automatic logic [7:0] rand_symbol();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26) return CHAR_UC_A + 8'(idx);
        if (idx < 52) return CHAR_LC_A + 8'(idx - 26);
        if (idx < 62) return CHAR_DIG_0 + 8'(idx - 52);
        return (idx == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return CHAR_LF;
            1: return CHAR_CR;
            2: return CHAR_SPACE;
            default: return CHAR_TAB;
        endcase
    endfunction

    task automatic clear_decoder();
        held_sextets[0] = 6'd0;
        held_sextets[1] = 6'd0;
        held_sextets[2] = 6'd0;
        third_pad = 1'b0;
        filled = 2'd0;
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic eos, input bit keep);
        t_decoded    outs [$];
        logic [6:0]  cv;
        logic [23:0] grp;
        if (!halted && !is_blank(ch)) begin
            symbols_seen++;
            cv = char_value(ch);
            if (cv[6]) begin
                outs.push_back('{data: 8'h00, bad: 1'b1, last: 1'b0});
                halted = 1'b1;
            end else if (filled < 2'd3) begin
                if (filled == 2'd2) third_pad = (ch == CHAR_PAD);
                held_sextets[filled] = cv[5:0];
                filled = filled + 2'd1;
            end else begin
                grp = {held_sextets[0], held_sextets[1], held_sextets[2], cv[5:0]};
                outs.push_back('{data: grp[23:16], bad: 1'b0, last: 1'b0});
                if (!third_pad) outs.push_back('{data: grp[15:8], bad: 1'b0, last: 1'b0});
                if (ch != CHAR_PAD) outs.push_back('{data: grp[7:0], bad: 1'b0, last: 1'b0});
                clear_decoder();
            end
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        if (eos) begin
            clear_decoder();
            halted = 1'b0;
        end
        if (keep) begin
            foreach (outs[i]) expected_bytes.push_back(outs[i]);
        end
    endtask

    task automatic send_item(input logic [7:0] ch, input logic eos, input logic typed,
                             input logic [1:0] n, input logic [23:0] bytes, input logic bad);
        i_push <= 1'b1;
        i_in_char <= ch;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_full);
        decode_char(ch, eos, !typed);
        if (typed) begin
            for (int k = 0; k < n; k++) begin
                expected_bytes.push_back('{data: bytes[23 - 8 * k -: 8], bad: bad,
                                           last: (k == n - 1)});
            end
        end
        if (burst_left == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
    endtask

    task automatic send_stream();
        logic [7:0] chars [$];
        int         groups;
        int         tail_pad;
        groups = $urandom_range(1, 6);
        tail_pad = $urandom_range(0, 2);
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 7) == 0) chars.push_back(rand_blank());
                if ($urandom_range(0, 79) == 0) chars.push_back(8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 19) == 0) chars.push_back(CHAR_PAD);
                else if (g == groups - 1 && k >= 4 - tail_pad) chars.push_back(CHAR_PAD);
                else chars.push_back(rand_symbol());
            end
        end
        case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 3)) chars.push_back(rand_symbol());
            1: chars.push_back(rand_blank());
            2: repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(0, 255)));
            default: ;
        endcase
        foreach (chars[i]) send_item(chars[i], i == chars.size() - 1, 1'b0, 2'd0, 24'd0, 1'b0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected word: out_byte %02h invalid %0b run_end %0b",
                       o_out_byte, o_invalid, o_run_end);
                failures++;
            end else begin
                popped = expected_bytes.pop_front();
                if (o_out_byte !== popped.data) begin
                    $error("out_byte: expected %02h, got %02h", popped.data, o_out_byte);
                    failures++;
                end
                if (o_invalid !== popped.bad) begin
                    $error("invalid: expected %0b, got %0b", popped.bad, o_invalid);
                    failures++;
                end
                if (o_run_end !== popped.last) begin
                    $error("run_end: expected %0b, got %0b", popped.last, o_run_end);
                    failures++;
                end
            end
        end
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        pop_cycle++;
        if (pop_cycle % 64 == 0) pop_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            i_pop <= 1'b0;
        end else if (finishing || pop_mode == 0) begin
            i_pop <= 1'b1;
        end else if (pop_mode == 1) begin
            i_pop <= 1'($urandom_range(0, 1));
        end else begin
            i_pop <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("base64_stream_decoder_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int random_base;
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        clear_decoder();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(DIRECTED[r].ch, DIRECTED[r].eos, DIRECTED[r].typed,
                      DIRECTED[r].n, DIRECTED[r].bytes, DIRECTED[r].bad);
        end
        wait_drained();
        random_base = symbols_seen;
        while (symbols_seen - random_base < RANDOM_ITEMS) begin
            if (!hold_done && symbols_seen - random_base > 120) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && symbols_seen - random_base > 260) begin
                wait_drained();
                pause_done = 1'b1;
            end
            send_stream();
        end
        wait_drained();
        finishing = 1'b1;
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("base64_stream_decoder_unit: match");
        end else begin
            $display("base64_stream_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
